@@ hw/rtl/bgd_pkg.sv @@
// shared types and constants for the button gesture detector
// no dependencies; imported by the top level and its checker
`default_nettype none

package bgd_pkg;

  // raw reads counted per sample word and the strict-majority vote needed
  localparam int READ_COUNT   = 4;
  localparam int RAW_W        = 4;
  localparam int VOTE_W       = 4;
  localparam int VOTE_NEEDED  = READ_COUNT / 2 + 1;

  localparam int TIME_W       = 32;
  localparam int LIMIT_W      = 31;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  localparam logic [LIMIT_W-1:0] DEBOUNCE_RESET  = 31'd20000;
  localparam logic [LIMIT_W-1:0] LONG_RESET      = 31'd500000;
  localparam logic [LIMIT_W-1:0] WINDOW_RESET    = 31'd350000;

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_LONG     = 2'd1;
  localparam logic [1:0] REG_WINDOW   = 2'd2;

  localparam logic [1:0] GESTURE_PRESS  = 2'd0;
  localparam logic [1:0] GESTURE_LONG   = 2'd1;
  localparam logic [1:0] GESTURE_DOUBLE = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEB_DOWN = 3'd1,
    PH_HELD     = 3'd2,
    PH_DEB_UP   = 3'd3,
    PH_WAIT     = 3'd4
  } phase_t;

  typedef struct packed {
    logic [RAW_W-1:0]  raw_reads;
    logic [TIME_W-1:0] now_time;
  } sample_t;

  typedef struct packed {
    logic       event_valid;
    logic [1:0] gesture;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/button_gesture_detector_top.sv @@
// button gesture detector: majority vote, debounce, press / long / double press
// depends on bgd_pkg
// an accepted sample word's result word is registered and valid in the cycle after it is taken
// throughput: one sample word per cycle; the result register parts the two sides,
// so a sample is taken whenever that register is empty or being drained
// reset (rst, synchronous): phase idle, timers and flags cleared, registers at defaults
`default_nettype none

module button_gesture_detector_top
  import bgd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  output logic                   sample_stall,
  input  wire sample_t           sample,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output result_t                result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic [LIMIT_W-1:0] debounce_time;
  logic [LIMIT_W-1:0] long_press_time;
  logic [LIMIT_W-1:0] double_window_time;

  phase_t             phase, phase_next;
  logic [TIME_W-1:0]  phase_start, phase_start_next;
  logic [TIME_W-1:0]  press_start, press_start_next;
  logic               long_reported, long_reported_next;
  logic               short_seen, short_seen_next;
  result_t            result_next;

  logic               accept;
  logic               down;
  logic [VOTE_W-1:0]  votes;
  logic [TIME_W-1:0]  now;
  logic [TIME_W-1:0]  phase_age;
  logic [TIME_W-1:0]  press_age;
  logic               over_debounce;
  logic               over_window;
  logic               over_long;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time      <= DEBOUNCE_RESET;
      long_press_time    <= LONG_RESET;
      double_window_time <= WINDOW_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_DEBOUNCE: debounce_time      <= pwdata[LIMIT_W-1:0];
        REG_LONG:     long_press_time    <= pwdata[LIMIT_W-1:0];
        REG_WINDOW:   double_window_time <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DEBOUNCE: prdata = {1'b0, debounce_time};
      REG_LONG:     prdata = {1'b0, long_press_time};
      REG_WINDOW:   prdata = {1'b0, double_window_time};
      default:      prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign sample_stall = result_valid && result_stall;
  assign accept       = sample_valid && !sample_stall;

  // ---------------- vote and elapsed times ----------------
  always_comb begin
    votes = '0;
    for (int i = 0; i < RAW_W; i++) begin
      if (i < READ_COUNT) begin
        votes = votes + VOTE_W'(sample.raw_reads[i]);
      end
    end
  end

  assign down      = (votes >= VOTE_W'(VOTE_NEEDED));
  assign now       = sample.now_time;
  assign phase_age = now - phase_start;
  assign press_age = now - press_start;

  // a wrapped difference with the top bit set counts as negative
  assign over_debounce = !phase_age[TIME_W-1] && (phase_age[LIMIT_W-1:0] > debounce_time);
  assign over_window   = !phase_age[TIME_W-1] &&
                         (phase_age[LIMIT_W-1:0] > double_window_time);
  assign over_long     = !press_age[TIME_W-1] && (press_age[LIMIT_W-1:0] > long_press_time);

  // ---------------- phase machine ----------------
  always_comb begin
    phase_next         = phase;
    phase_start_next   = phase_start;
    press_start_next   = press_start;
    long_reported_next = long_reported;
    short_seen_next    = short_seen;
    result_next        = '0;

    case (phase)
      PH_DEB_DOWN: begin
        if (!down) begin
          phase_next = PH_IDLE;
        end else if (over_debounce) begin
          phase_next         = PH_HELD;
          press_start_next   = phase_start;
          long_reported_next = 1'b0;
        end
      end
      PH_HELD: begin
        if (!down) begin
          phase_next       = PH_DEB_UP;
          phase_start_next = now;
        end else if (!long_reported && over_long) begin
          long_reported_next      = 1'b1;
          short_seen_next         = 1'b0;
          result_next.event_valid = 1'b1;
          result_next.gesture     = GESTURE_LONG;
        end
      end
      PH_DEB_UP: begin
        if (down) begin
          phase_next = PH_HELD;
        end else if (over_debounce) begin
          if (long_reported) begin
            phase_next      = PH_IDLE;
            short_seen_next = 1'b0;
          end else if (short_seen) begin
            phase_next              = PH_IDLE;
            short_seen_next         = 1'b0;
            result_next.event_valid = 1'b1;
            result_next.gesture     = GESTURE_DOUBLE;
          end else begin
            phase_next       = PH_WAIT;
            short_seen_next  = 1'b1;
            phase_start_next = now;
          end
        end
      end
      PH_WAIT: begin
        if (down) begin
          phase_next       = PH_DEB_DOWN;
          phase_start_next = now;
        end else if (over_window) begin
          phase_next              = PH_IDLE;
          short_seen_next         = 1'b0;
          result_next.event_valid = 1'b1;
          result_next.gesture     = GESTURE_PRESS;
        end
      end
      default: begin
        // idle
        if (down) begin
          phase_next       = PH_DEB_DOWN;
          phase_start_next = now;
        end else if (short_seen && over_window) begin
          phase_next              = PH_IDLE;
          short_seen_next         = 1'b0;
          result_next.event_valid = 1'b1;
          result_next.gesture     = GESTURE_PRESS;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      phase_start   <= '0;
      press_start   <= '0;
      long_reported <= 1'b0;
      short_seen    <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      phase_start   <= phase_start_next;
      press_start   <= press_start_next;
      long_reported <= long_reported_next;
      short_seen    <= short_seen_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bgd_checker.sv @@
// port-level checks for the button gesture detector, bound to the top level
// depends on bgd_pkg and button_gesture_detector_top
`default_nettype none

module bgd_checker
  import bgd_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    sample_valid,
  input wire logic    sample_stall,
  input wire logic    result_valid,
  input wire logic    result_stall,
  input wire result_t result
);

  // a stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // every accepted sample word yields a result word on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> result_valid)
    else $error("accepted sample word produced no result word");

  // a full, stalled result register must block new samples
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> sample_stall)
    else $error("sample taken while result register blocked");

  a_gesture_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.gesture == GESTURE_PRESS) || (result.gesture == GESTURE_LONG) ||
                     (result.gesture == GESTURE_DOUBLE))
    else $error("undefined gesture code");

  // no event means a zero gesture field
  a_quiet_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.event_valid |-> result.gesture == GESTURE_PRESS)
    else $error("gesture field set without an event");

endmodule

bind button_gesture_detector_top bgd_checker u_bgd_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

@@ tb/gesture_checker.sv @@
`timescale 1ns / 1ps
// checker for the button gesture detector: watches the sample, result and apb ports,
// keeps its own copy of the gesture machine and compares every result word
// depends on bgd_pkg
module gesture_checker
  import bgd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  input  logic              sample_stall,
  input  sample_t           sample,
  input  logic              result_valid,
  input  logic              result_stall,
  input  result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              pready,
  output int                error_count,
  output int                words_in_flight
);

  logic [LIMIT_W-1:0] debounce_us = DEBOUNCE_RESET;
  logic [LIMIT_W-1:0] long_us     = LONG_RESET;
  logic [LIMIT_W-1:0] window_us   = WINDOW_RESET;
  phase_t             phase       = PH_IDLE;
  logic [TIME_W-1:0]  phase_t0    = '0;
  logic [TIME_W-1:0]  press_t0    = '0;
  logic               long_done   = 1'b0;
  logic               short_seen  = 1'b0;
  result_t            expected_gestures[$];
  int                 fails       = 0;

  assign error_count = fails;

  // wrapped difference, read as signed; must be strictly past the limit
  function automatic logic past_limit(input logic [TIME_W-1:0] now,
                                      input logic [TIME_W-1:0] start,
                                      input logic [LIMIT_W-1:0] limit);
    logic [TIME_W-1:0] span;
    span = now - start;
    return !span[TIME_W-1] && (span > TIME_W'(limit));
  endfunction

  task automatic advance_gesture(input sample_t s, output result_t r);
    logic              down;
    logic [TIME_W-1:0] now;
    down = $countones(s.raw_reads[READ_COUNT-1:0]) >= VOTE_NEEDED;
    now  = s.now_time;
    r    = '0;
    case (phase)
      PH_DEB_DOWN: begin
        if (!down) begin
          phase = PH_IDLE;
        end else if (past_limit(now, phase_t0, debounce_us)) begin
          phase     = PH_HELD;
          press_t0  = phase_t0;
          long_done = 1'b0;
        end
      end
      PH_HELD: begin
        if (!down) begin
          phase    = PH_DEB_UP;
          phase_t0 = now;
        end else if (!long_done && past_limit(now, press_t0, long_us)) begin
          long_done     = 1'b1;
          short_seen    = 1'b0;
          r.event_valid = 1'b1;
          r.gesture     = GESTURE_LONG;
        end
      end
      PH_DEB_UP: begin
        if (down) begin
          phase = PH_HELD;
        end else if (past_limit(now, phase_t0, debounce_us)) begin
          if (long_done) begin
            phase      = PH_IDLE;
            short_seen = 1'b0;
          end else if (short_seen) begin
            phase         = PH_IDLE;
            short_seen    = 1'b0;
            r.event_valid = 1'b1;
            r.gesture     = GESTURE_DOUBLE;
          end else begin
            short_seen = 1'b1;
            phase      = PH_WAIT;
            phase_t0   = now;
          end
        end
      end
      PH_WAIT: begin
        if (down) begin
          phase    = PH_DEB_DOWN;
          phase_t0 = now;
        end else if (past_limit(now, phase_t0, window_us)) begin
          phase         = PH_IDLE;
          short_seen    = 1'b0;
          r.event_valid = 1'b1;
          r.gesture     = GESTURE_PRESS;
        end
      end
      default: begin
        if (down) begin
          phase    = PH_DEB_DOWN;
          phase_t0 = now;
        end else if (short_seen && past_limit(now, phase_t0, window_us)) begin
          // a second press that bounced out still ends as a single press
          phase         = PH_IDLE;
          short_seen    = 1'b0;
          r.event_valid = 1'b1;
          r.gesture     = GESTURE_PRESS;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    result_t           fresh;
    result_t           oldest;
    logic [DATA_W-1:0] held_value;
    logic              decoded;
    if (rst) begin
      debounce_us = DEBOUNCE_RESET;
      long_us     = LONG_RESET;
      window_us   = WINDOW_RESET;
      phase       = PH_IDLE;
      phase_t0    = '0;
      press_t0    = '0;
      long_done   = 1'b0;
      short_seen  = 1'b0;
      expected_gestures.delete();
      words_in_flight <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_DEBOUNCE: debounce_us = pwdata[LIMIT_W-1:0];
          REG_LONG:     long_us     = pwdata[LIMIT_W-1:0];
          REG_WINDOW:   window_us   = pwdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (psel && penable && !pwrite && pready) begin
        decoded = 1'b1;
        case (paddr[ADDR_W-1:2])
          REG_DEBOUNCE: held_value = DATA_W'(debounce_us);
          REG_LONG:     held_value = DATA_W'(long_us);
          REG_WINDOW:   held_value = DATA_W'(window_us);
          default: begin
            held_value = '0;
            decoded    = 1'b0;
          end
        endcase
        if (decoded && prdata !== held_value) begin
          fails++;
          $display("%0t: register %0d read back: expected %0d, got %0d",
                   $time, paddr[ADDR_W-1:2], held_value, prdata);
        end
      end
      if (sample_valid && !sample_stall) begin
        advance_gesture(sample, fresh);
        expected_gestures.push_back(fresh);
      end
      if (result_valid && !result_stall) begin
        if (expected_gestures.size() == 0) begin
          fails++;
          $display("%0t: stray result word: expected none, got valid=%0b gesture=%0d",
                   $time, result.event_valid, result.gesture);
        end else begin
          oldest = expected_gestures.pop_front();
          if (result.event_valid !== oldest.event_valid) begin
            fails++;
            $display("%0t: event_valid: expected %0b, got %0b",
                     $time, oldest.event_valid, result.event_valid);
          end
          if (result.gesture !== oldest.gesture) begin
            fails++;
            $display("%0t: gesture: expected %0d, got %0d", $time, oldest.gesture, result.gesture);
          end
        end
      end
      words_in_flight <= expected_gestures.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// top of the button gesture detector testbench: clock, reset, stimulus and verdict
// depends on bgd_pkg, button_gesture_detector_top and gesture_checker
module testbench
  import bgd_pkg::*;
();

  localparam logic [1:0] REG_SPARE   = 2'd3;  // address decoded by no register
  localparam int         HOLD_OFF    = 4;
  localparam int         POLL_TARGET = 800;

  logic              clk          = 1'b0;
  logic              rst;
  logic              sample_valid;
  logic              sample_stall;
  sample_t           sample;
  logic              result_valid;
  logic              result_stall = 1'b0;
  result_t           result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                error_count;
  int                words_in_flight;
  logic              no_idle      = 1'b0;
  int                stall_left   = 0;
  int                polls_sent   = 0;
  logic [TIME_W-1:0] clock_us;
  logic [LIMIT_W-1:0] deb_cfg;
  logic [LIMIT_W-1:0] long_cfg;
  logic [LIMIT_W-1:0] window_cfg;

  always #1 clk = ~clk;

  button_gesture_detector_top dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  gesture_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .sample          (sample),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result          (result),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .error_count     (error_count),
    .words_in_flight (words_in_flight)
  );

  // result side backpressure in random bursts
  always @(posedge clk) begin
    if (rst || no_idle) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      result_stall <= 1'b1;
      stall_left   <= $urandom_range(0, 3);
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic send_poll(input logic [RAW_W-1:0] raw, input logic [TIME_W-1:0] stamp);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    sample       <= '{raw_reads: raw, now_time: stamp};
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    polls_sent++;
  endtask

  // wait until every sample word has its result, then let the pipe go quiet
  task automatic settle();
    sample_valid <= 1'b0;
    do @(posedge clk); while (words_in_flight != 0);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [1:0] index,
                            input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [LIMIT_W-1:0] d, input logic [LIMIT_W-1:0] l,
                            input logic [LIMIT_W-1:0] w);
    // the top data bit is not stored, so it gets random values
    apb_access(1'b1, REG_DEBOUNCE, {1'($urandom_range(0, 1)), d});
    apb_access(1'b1, REG_LONG,     {1'($urandom_range(0, 1)), l});
    apb_access(1'b1, REG_WINDOW,   {1'($urandom_range(0, 1)), w});
    apb_access(1'b0, REG_DEBOUNCE, '0);
    apb_access(1'b0, REG_LONG,     '0);
    apb_access(1'b0, REG_WINDOW,   '0);
    deb_cfg    = d;
    long_cfg   = l;
    window_cfg = w;
  endtask

  function automatic logic [RAW_W-1:0] pick_reads(input logic pressed);
    logic [RAW_W-1:0] raw;
    do raw = RAW_W'($urandom_range(0, 2**RAW_W - 1));
    while (($countones(raw) >= VOTE_NEEDED) != pressed);
    return raw;
  endfunction

  // keep one level for longer than span, with the odd bounce thrown in
  task automatic hold_level(input logic pressed, input logic [TIME_W-1:0] span);
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] step;
    t0   = clock_us;
    step = (span > 4) ? span / 4 : 1;
    do begin
      clock_us += $urandom_range(1, step);
      if ($urandom_range(0, 9) == 0) send_poll(pick_reads(!pressed), clock_us);
      else send_poll(pick_reads(pressed), clock_us);
    end while (clock_us - t0 <= span);
  endtask

  task automatic random_gesture();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: begin
        hold_level(1'b1, deb_cfg + 1 + $urandom_range(0, long_cfg / 2));
        hold_level(1'b0, deb_cfg + 1 + $urandom_range(0, window_cfg * 2 + 2));
      end
      3, 4: begin
        hold_level(1'b1, long_cfg + deb_cfg + 1 + $urandom_range(0, long_cfg / 2 + 1));
        hold_level(1'b0, deb_cfg + 1 + $urandom_range(0, window_cfg + 1));
      end
      5, 6, 7: begin
        hold_level(1'b1, deb_cfg + 1 + $urandom_range(0, long_cfg / 2));
        hold_level(1'b0, deb_cfg + 1 + $urandom_range(0, window_cfg / 2));
        hold_level(1'b1, deb_cfg + 1 + $urandom_range(0, long_cfg / 2));
        hold_level(1'b0, deb_cfg + 1 + $urandom_range(0, window_cfg * 2 + 2));
      end
      8: begin
        repeat ($urandom_range(2, 8)) begin
          clock_us += $urandom_range(0, deb_cfg + 2);
          send_poll(RAW_W'($urandom_range(0, 2**RAW_W - 1)), clock_us);
        end
      end
      default: begin
        // jump of half the wrap or more: elapsed reads negative
        clock_us += 32'h8000_0000 + $urandom_range(0, 32'h7FFF_FFFF);
        send_poll(pick_reads(1'($urandom_range(0, 1))), clock_us);
      end
    endcase
  endtask

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int phase_no;
    int phase_end;
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    deb_cfg      = DEBOUNCE_RESET;
    long_cfg     = LONG_RESET;
    window_cfg   = WINDOW_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset limits: debounce edges, a double press, a single press, a long press
    send_poll(4'b0000, 32'd0);
    send_poll(4'b0111, 32'd100);
    send_poll(4'b1111, 32'd20100);
    send_poll(4'b1110, 32'd20101);
    send_poll(4'b0011, 32'd30000);
    send_poll(4'b1011, 32'd30010);
    send_poll(4'b0000, 32'd40000);
    send_poll(4'b0001, 32'd60001);
    send_poll(4'b1101, 32'd100000);
    send_poll(4'b1111, 32'd120001);
    send_poll(4'b0000, 32'd130000);
    send_poll(4'b0100, 32'd150001);
    send_poll(4'b1111, 32'd200000);
    send_poll(4'b1111, 32'd220001);
    send_poll(4'b1000, 32'd230000);
    send_poll(4'b0010, 32'd250001);
    send_poll(4'b1001, 32'd600001);
    send_poll(4'b0110, 32'd600002);
    send_poll(4'b1111, 32'd700000);
    send_poll(4'b1111, 32'd720001);
    send_poll(4'b1111, 32'd1200000);
    send_poll(4'b1111, 32'd1200001);
    send_poll(4'b1111, 32'd1300000);
    send_poll(4'b0000, 32'd1300001);
    send_poll(4'b0000, 32'd1320002);
    settle();

    // largest limits: nothing can ever be past them
    set_limits('1, '1, '1);
    send_poll(4'b1111, 32'hFFFF_FFFF);
    send_poll(4'b1111, 32'h0000_0000);
    repeat (10) send_poll(RAW_W'($urandom_range(0, 2**RAW_W - 1)), $urandom());
    settle();
    apb_access(1'b1, REG_SPARE, $urandom());

    clock_us   = '0;
    polls_sent = 0;
    phase_no   = 0;
    while (polls_sent < POLL_TARGET) begin
      settle();
      case (phase_no % 4)
        0: set_limits('0, '0, '0);
        1: set_limits(LIMIT_W'($urandom_range(0, 40)), LIMIT_W'($urandom_range(40, 300)),
                      LIMIT_W'($urandom_range(20, 200)));
        2: set_limits(LIMIT_W'($urandom_range(1000, 20000)),
                      LIMIT_W'($urandom_range(20000, 200000)),
                      LIMIT_W'($urandom_range(10000, 100000)));
        default: set_limits(LIMIT_W'($urandom_range(0, 8)), LIMIT_W'($urandom_range(0, 60)),
                            LIMIT_W'($urandom_range(0, 40)));
      endcase
      if (phase_no % 2 == 1) clock_us = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      no_idle   <= (phase_no == 2) || (polls_sent >= POLL_TARGET - 150);
      phase_end = polls_sent + 120;
      while (polls_sent < phase_end && polls_sent < POLL_TARGET) random_gesture();
      phase_no++;
    end
    settle();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ button_gesture_detector_top.f @@
hw/rtl/bgd_pkg.sv
hw/rtl/button_gesture_detector_top.sv
hw/rtl/bgd_checker.sv
tb/gesture_checker.sv
tb/testbench.sv
